// ===== design/lewh_pkg.sv =====
// Shared types, codes and constants of the line editor with history.
package lewh_pkg;

   localparam int LINE_LENGTH_DEF   = 80;
   localparam int HISTORY_DEPTH_DEF = 32;
   localparam int QUEUE_DEPTH       = 2;
   localparam int FKEY_COUNT        = 24;
   localparam int FKEY_PER_BANK     = 12;
   localparam int REQ_WIDTH         = 24;
   localparam int RSP_WIDTH         = 80;

   localparam logic [7:0] CHR_PROMPT = 8'h3A;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_S      = 8'h53;
   localparam logic [7:0] CHR_F      = 8'h46;
   localparam logic [7:0] CHR_ONE    = 8'h31;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NUL    = 8'h00;

   typedef enum logic [3:0] {
      CMD_BEGIN  = 4'd0,
      CMD_CHAR   = 4'd1,
      CMD_CLEAR  = 4'd2,
      CMD_HOME   = 4'd3,
      CMD_END    = 4'd4,
      CMD_LEFT   = 4'd5,
      CMD_RIGHT  = 4'd6,
      CMD_PREV   = 4'd7,
      CMD_NEXT   = 4'd8,
      CMD_INSTOG = 4'd9,
      CMD_BKSP   = 4'd10,
      CMD_DEL    = 4'd11,
      CMD_ENTER  = 4'd12,
      CMD_FKEY   = 4'd13
   } cmd_type;

   typedef enum logic [3:0] {
      OP_BEGIN, OP_CHAR, OP_CLEAR, OP_HOME, OP_END, OP_LEFT, OP_RIGHT, OP_PREV,
      OP_NEXT, OP_INSTOG, OP_BKSP, OP_DEL, OP_ENTER, OP_FKEY, OP_NOP
   } op_kind_type;

   typedef struct packed {
      op_kind_type      kind;
      logic [7:0]       key_char;
      logic [3:0][7:0]  name;
      logic [2:0]       name_len;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } q_head_type;

   typedef struct packed {
      logic       full;
      logic [1:0] count;
   } q_stat_type;

endpackage

// ===== design/line_editor_with_history_top.sv =====
// Top level of the keystroke line editor with history ring.
//
//   channel | direction | handshake             | content
//   req     | in        | req_tvalid/req_tready | one key command
//   rsp     | out       | rsp_tvalid/rsp_tready | line chunks, tlast on the final one
//
// Each key gives (LINE_LENGTH+7)/8 chunk transfers, one per cycle when rsp_tready is high.
// Plain edits finish in the idle state before the chunks; End scans the columns down
// from the last text column; Previous/Next search the history ring for a non-empty row,
// copy it in and scan it; Enter compares the line with every history row through the
// single history RAM read port, then writes it back. Reset is synchronous; a two-entry
// queue keeps taking keys until it is full while the back end works or rsp stalls.
module line_editor_with_history_top
   import lewh_pkg::*;
#(
   parameter int LINE_LENGTH   = LINE_LENGTH_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [3:0] command, [11:4] key_char, [16:12] function_index
   input  logic [REQ_WIDTH-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [63:0] line_chunk, [67:64] chunk_index, [74:68] cursor_column,
   // [75] insert_mode, [76] line_done
   output logic [RSP_WIDTH-1:0] rsp_tdata,
   output logic                 rsp_tlast
);

   localparam int CHUNK_COUNT = (LINE_LENGTH + 7) / 8;

   logic       push;
   logic       pop;
   op_type     push_op;
   q_head_type head;
   q_stat_type q_stat;

   lewh_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .push       (push),
      .push_op    (push_op)
   );

   lewh_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head    (head),
      .q_stat  (q_stat)
   );

   lewh_back #(
      .LINE_LENGTH   (LINE_LENGTH),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req_tready) else $error("queue full but req ready");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[67:64] == 4'(CHUNK_COUNT - 1))
      else $error("last chunk carries wrong index");

   a_chunks_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a line transfer");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid) else $error("pop from empty queue");

endmodule

// ===== design/lewh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lewh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2560
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/lewh_front.sv =====
// Front end: takes key transfers and classifies them into queued operations.
module lewh_front
   import lewh_pkg::*;
(
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_WIDTH-1:0] req_tdata,
   input  q_stat_type           q_stat,
   output logic                 push,
   output op_type               push_op
);

   logic [3:0] cmd;
   logic [7:0] ch;
   logic [4:0] fi;

   assign cmd        = req_tdata[3:0];
   assign ch         = req_tdata[11:4];
   assign fi         = req_tdata[16:12];
   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      logic       bank;
      logic [4:0] n;
      logic [3:0] num;
      logic [3:0] dig;
      logic       two;
      logic [7:0] dc;
      bank = (fi >= 5'(FKEY_PER_BANK));
      n    = bank ? fi - 5'(FKEY_PER_BANK) : fi;
      num  = 4'(n) + 4'd1;
      two  = (num >= 4'd10);
      dig  = two ? num - 4'd10 : num;
      dc   = CHR_ZERO + 8'(dig);

      push_op          = '0;
      push_op.key_char = ch;
      if (!bank && !two) begin
         push_op.name     = {CHR_NUL, CHR_NUL, dc, CHR_F};
         push_op.name_len = 3'd2;
      end else if (!bank) begin
         push_op.name     = {CHR_NUL, dc, CHR_ONE, CHR_F};
         push_op.name_len = 3'd3;
      end else if (!two) begin
         push_op.name     = {CHR_NUL, dc, CHR_F, CHR_S};
         push_op.name_len = 3'd3;
      end else begin
         push_op.name     = {dc, CHR_ONE, CHR_F, CHR_S};
         push_op.name_len = 3'd4;
      end

      case (cmd_type'(cmd))
         CMD_BEGIN:  push_op.kind = OP_BEGIN;
         CMD_CHAR:   push_op.kind = OP_CHAR;
         CMD_CLEAR:  push_op.kind = OP_CLEAR;
         CMD_HOME:   push_op.kind = OP_HOME;
         CMD_END:    push_op.kind = OP_END;
         CMD_LEFT:   push_op.kind = OP_LEFT;
         CMD_RIGHT:  push_op.kind = OP_RIGHT;
         CMD_PREV:   push_op.kind = OP_PREV;
         CMD_NEXT:   push_op.kind = OP_NEXT;
         CMD_INSTOG: push_op.kind = OP_INSTOG;
         CMD_BKSP:   push_op.kind = OP_BKSP;
         CMD_DEL:    push_op.kind = OP_DEL;
         CMD_ENTER:  push_op.kind = OP_ENTER;
         CMD_FKEY:   push_op.kind = (fi < 5'(FKEY_COUNT)) ? OP_FKEY : OP_NOP;
         default:    push_op.kind = OP_NOP;
      endcase
   end

endmodule

// ===== design/lewh_queue.sv =====
// Short operation queue between the front end and the back end.
module lewh_queue
   import lewh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  op_type     push_op,
   input  logic       pop,
   output q_head_type head,
   output q_stat_type q_stat
);

   op_type     slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head.valid  = (count_ff != 2'd0);
   assign head.op     = slot_ff[rd_ptr_ff];
   assign q_stat.full = (count_ff == 2'(QUEUE_DEPTH));
   assign q_stat.count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== design/lewh_back.sv =====
// Back end: runs queued operations on the line and history, then sends the line.
module lewh_back
   import lewh_pkg::*;
#(
   parameter int LINE_LENGTH   = LINE_LENGTH_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  q_head_type           head,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_WIDTH-1:0] rsp_tdata,
   output logic                 rsp_tlast
);

   localparam int L   = LINE_LENGTH;
   localparam int D   = HISTORY_DEPTH;
   localparam int CW  = $clog2(L);
   localparam int RW  = $clog2(D);
   localparam int AW  = $clog2(D * L);
   localparam int NCH = (L + 7) / 8;
   localparam int KW  = $clog2(NCH);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEEK, ST_BROWSE, ST_COPY, ST_CMP, ST_WRITE, ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [7:0]       line_ff [L];
   logic [7:0]       line_in [L];
   logic [CW-1:0]    cursor_ff, cursor_in;
   logic             ins_ff, ins_in;
   logic [RW-1:0]    browse_ff, browse_in;
   logic [RW-1:0]    store_ff, store_in;
   logic [D-1:0]     rvalid_ff, rvalid_in;
   logic [D-1:0]     nz_ff, nz_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic [RW-1:0]    step_ff, step_in;
   logic [RW-1:0]    bidx_ff, bidx_in;
   logic             dir_ff, dir_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic             iss_ff, iss_in;
   logic             done_ff, done_in;
   logic             zero_ff, zero_in;
   logic             eq_ff, eq_in;
   logic             p_vld_ff, p_vld_in;
   logic [RW-1:0]    p_row_ff, p_row_in;
   logic [CW-1:0]    p_col_ff, p_col_in;
   logic [7:0]       p_ref_ff, p_ref_in;
   logic             p_rv_ff, p_rv_in;
   logic [KW-1:0]    chunk_ff, chunk_in;
   logic             ov_ff, ov_in;
   logic [RSP_WIDTH-1:0] odata_ff, odata_in;
   logic             olast_ff, olast_in;

   logic             ram_we;
   logic [AW-1:0]    ram_raddr;
   logic [7:0]       ram_q;
   logic [L-1:0]     nonsp;
   logic [NCH-1:0][63:0] words;

   lewh_ram #(.WIDTH(8), .DEPTH(D * L)) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (line_ff[0]),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;
   assign ram_raddr  = addr_ff;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         nonsp[i] = (line_ff[i] != CHR_SPACE);
      end
      for (int i = 0; i < NCH * 8; i++) begin
         words[i / 8][(i % 8) * 8 +: 8] = (i < L) ? line_ff[(i < L) ? i : 0] : CHR_NUL;
      end
   end

   always_comb begin
      logic [CW:0]   fk_end;
      logic [CW:0]   off;
      logic [7:0]    rd_byte;
      logic          eqn;
      logic [RW-1:0] nidx;
      logic [CW-1:0] nc;
      logic [CW-1:0] c;

      state_in  = state_ff;
      line_in   = line_ff;
      cursor_in = cursor_ff;
      ins_in    = ins_ff;
      browse_in = browse_ff;
      store_in  = store_ff;
      rvalid_in = rvalid_ff;
      nz_in     = nz_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      scan_in   = scan_ff;
      step_in   = step_ff;
      bidx_in   = bidx_ff;
      dir_in    = dir_ff;
      addr_in   = addr_ff;
      iss_in    = iss_ff;
      done_in   = done_ff;
      zero_in   = zero_ff;
      eq_in     = eq_ff;
      p_vld_in  = 1'b0;
      p_row_in  = p_row_ff;
      p_col_in  = p_col_ff;
      p_ref_in  = p_ref_ff;
      p_rv_in   = p_rv_ff;
      chunk_in  = chunk_ff;
      ov_in     = ov_ff && !rsp_tready;
      odata_in  = odata_ff;
      olast_in  = olast_ff;
      ram_we    = 1'b0;
      pop       = 1'b0;
      c         = cursor_ff;
      fk_end    = '0;
      off       = '0;
      nidx      = '0;
      nc        = '0;
      eqn       = 1'b0;
      rd_byte = p_rv_ff ? ram_q :
                ((p_row_ff == '0 && p_col_ff < CW'(L - 1)) ? CHR_SPACE : CHR_NUL);

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               done_in  = 1'b0;
               state_in = ST_EMIT;
               case (head.op.kind)
                  OP_BEGIN, OP_CLEAR: begin
                     for (int i = 0; i < L; i++) begin
                        line_in[i] = (i == 0) ? CHR_PROMPT : (i < L - 1) ? CHR_SPACE : CHR_NUL;
                     end
                     cursor_in = CW'(1);
                     if (head.op.kind == OP_BEGIN) begin
                        browse_in = store_ff;
                     end
                  end
                  OP_HOME:   cursor_in = CW'(1);
                  OP_LEFT:   if (c > CW'(1)) cursor_in = c - CW'(1);
                  OP_RIGHT:  if (c < CW'(L - 1)) cursor_in = c + CW'(1);
                  OP_INSTOG: ins_in = !ins_ff;
                  OP_CHAR: begin
                     for (int i = 0; i < L; i++) begin
                        if (c < CW'(L - 1) && CW'(i) == c) begin
                           line_in[i] = head.op.key_char;
                        end else if (ins_ff && c < CW'(L - 2) && CW'(i) > c && i <= L - 2) begin
                           line_in[i] = line_ff[(i > 0) ? i - 1 : 0];
                        end
                     end
                     if (c < CW'(L - 1)) cursor_in = c + CW'(1);
                  end
                  OP_BKSP: begin
                     if (c > CW'(1)) begin
                        for (int i = 0; i < L - 2; i++) begin
                           if (CW'(i) >= c - CW'(1)) line_in[i] = line_ff[i + 1];
                        end
                        line_in[L - 2] = CHR_SPACE;
                        cursor_in = c - CW'(1);
                     end
                  end
                  OP_DEL: begin
                     if (c < CW'(L - 1)) begin
                        for (int i = 0; i < L - 2; i++) begin
                           if (CW'(i) >= c) line_in[i] = line_ff[i + 1];
                        end
                        line_in[L - 2] = CHR_SPACE;
                     end
                  end
                  OP_END: begin
                     scan_in  = CW'(L - 2);
                     zero_in  = 1'b0;
                     state_in = ST_SEEK;
                  end
                  OP_PREV, OP_NEXT: begin
                     dir_in   = (head.op.kind == OP_NEXT);
                     bidx_in  = browse_ff;
                     step_in  = '0;
                     state_in = ST_BROWSE;
                  end
                  OP_ENTER: begin
                     done_in  = 1'b1;
                     addr_in  = '0;
                     row_in   = '0;
                     col_in   = '0;
                     iss_in   = 1'b1;
                     state_in = ST_CMP;
                  end
                  OP_FKEY: begin
                     done_in = 1'b1;
                     fk_end  = {1'b0, c} + (CW + 1)'(head.op.name_len);
                     if (fk_end > (CW + 1)'(L - 1)) fk_end = (CW + 1)'(L - 1);
                     for (int i = 0; i < L - 1; i++) begin
                        off = (CW + 1)'(i) - {1'b0, c};
                        if (CW'(i) >= c && off < (CW + 1)'(head.op.name_len)) begin
                           line_in[i] = head.op.name[off[1:0]];
                        end
                     end
                     for (int i = 0; i < L; i++) begin
                        if ((CW + 1)'(i) == fk_end) line_in[i] = CHR_NUL;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_SEEK: begin
            // walk down from the last text column to the first non-space byte
            if (nonsp[scan_ff] || scan_ff == '0) begin
               nc        = nonsp[scan_ff] ? scan_ff + CW'(1) : '0;
               cursor_in = nc;
               if (zero_ff) begin
                  for (int i = 0; i < L; i++) begin
                     if (CW'(i) == nc) line_in[i] = CHR_NUL;
                  end
               end
               state_in = ST_EMIT;
            end else begin
               scan_in = scan_ff - CW'(1);
            end
         end

         ST_BROWSE: begin
            if (dir_ff) nidx = (bidx_ff == RW'(D - 1)) ? '0 : bidx_ff + RW'(1);
            else        nidx = (bidx_ff == '0) ? RW'(D - 1) : bidx_ff - RW'(1);
            if (nz_ff[nidx]) begin
               browse_in = nidx;
               row_in    = nidx;
               addr_in   = AW'(nidx) * AW'(L);
               col_in    = '0;
               iss_in    = 1'b1;
               state_in  = ST_COPY;
            end else if (step_ff == RW'(D - 1)) begin
               state_in = ST_EMIT;
            end else begin
               bidx_in = nidx;
               step_in = step_ff + RW'(1);
            end
         end

         ST_COPY: begin
            if (iss_ff) begin
               p_vld_in = 1'b1;
               p_row_in = row_ff;
               p_col_in = col_ff;
               p_rv_in  = rvalid_ff[row_ff];
               addr_in  = addr_ff + AW'(1);
               col_in   = col_ff + CW'(1);
               if (col_ff == CW'(L - 1)) iss_in = 1'b0;
            end
            // shift the row in from the top end
            if (p_vld_ff) begin
               for (int i = 0; i < L - 1; i++) line_in[i] = line_ff[i + 1];
               line_in[L - 1] = rd_byte;
               if (p_col_ff == CW'(L - 1)) begin
                  scan_in  = CW'(L - 2);
                  zero_in  = 1'b0;
                  state_in = ST_SEEK;
               end
            end
         end

         ST_CMP: begin
            if (iss_ff) begin
               p_vld_in = 1'b1;
               p_row_in = row_ff;
               p_col_in = col_ff;
               p_ref_in = line_ff[0];
               p_rv_in  = rvalid_ff[row_ff];
               // rotate so column zero always holds the column being compared
               for (int i = 0; i < L - 1; i++) line_in[i] = line_ff[i + 1];
               line_in[L - 1] = line_ff[0];
               addr_in = addr_ff + AW'(1);
               if (col_ff == CW'(L - 1)) begin
                  col_in = '0;
                  row_in = row_ff + RW'(1);
                  if (row_ff == RW'(D - 1)) iss_in = 1'b0;
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
            if (p_vld_ff) begin
               eqn   = (rd_byte == p_ref_ff) && (p_col_ff == '0 || eq_ff);
               eq_in = eqn;
               if (p_col_ff == CW'(L - 1) && eqn) store_in = p_row_ff;
               if (p_col_ff == CW'(L - 1) && p_row_ff == RW'(D - 1)) begin
                  row_in   = store_in;
                  addr_in  = AW'(store_in) * AW'(L);
                  col_in   = '0;
                  state_in = ST_WRITE;
               end
            end
         end

         ST_WRITE: begin
            ram_we = 1'b1;
            for (int i = 0; i < L - 1; i++) line_in[i] = line_ff[i + 1];
            line_in[L - 1] = line_ff[0];
            if (col_ff == '0) begin
               nz_in[row_ff]     = (line_ff[0] != CHR_NUL);
               rvalid_in[row_ff] = 1'b1;
            end
            addr_in = addr_ff + AW'(1);
            col_in  = col_ff + CW'(1);
            if (col_ff == CW'(L - 1)) begin
               store_in = (store_ff == RW'(D - 1)) ? '0 : store_ff + RW'(1);
               scan_in  = CW'(L - 2);
               zero_in  = 1'b1;
               state_in = ST_SEEK;
            end
         end

         ST_EMIT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in    = 1'b1;
               odata_in = {3'b000, done_ff, ins_ff, 7'(cursor_ff), 4'(chunk_ff), words[chunk_ff]};
               olast_in = (chunk_ff == KW'(NCH - 1));
               if (chunk_ff == KW'(NCH - 1)) begin
                  chunk_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  chunk_in = chunk_ff + KW'(1);
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         for (int i = 0; i < L; i++) begin
            line_ff[i] <= (i == 0) ? CHR_PROMPT : (i < L - 1) ? CHR_SPACE : CHR_NUL;
         end
         cursor_ff <= CW'(1);
         ins_ff    <= 1'b1;
         browse_ff <= '0;
         store_ff  <= '0;
         rvalid_ff <= '0;
         nz_ff     <= D'(1);
         iss_ff    <= 1'b0;
         p_vld_ff  <= 1'b0;
         chunk_ff  <= '0;
         ov_ff     <= 1'b0;
         done_ff   <= 1'b0;
         zero_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         line_ff   <= line_in;
         cursor_ff <= cursor_in;
         ins_ff    <= ins_in;
         browse_ff <= browse_in;
         store_ff  <= store_in;
         rvalid_ff <= rvalid_in;
         nz_ff     <= nz_in;
         iss_ff    <= iss_in;
         p_vld_ff  <= p_vld_in;
         chunk_ff  <= chunk_in;
         ov_ff     <= ov_in;
         done_ff   <= done_in;
         zero_ff   <= zero_in;
      end
      col_ff   <= col_in;
      row_ff   <= row_in;
      scan_ff  <= scan_in;
      step_ff  <= step_in;
      bidx_ff  <= bidx_in;
      dir_ff   <= dir_in;
      addr_ff  <= addr_in;
      eq_ff    <= eq_in;
      p_row_ff <= p_row_in;
      p_col_ff <= p_col_in;
      p_ref_ff <= p_ref_in;
      p_rv_ff  <= p_rv_in;
      odata_ff <= odata_in;
      olast_ff <= olast_in;
   end

endmodule

// ===== sim/line_editor_with_history_top_test.sv =====
// Testbench for the keystroke line editor: random and directed keys, chunk-by-chunk checking.
module line_editor_with_history_top_test;
   import lewh_pkg::*;

   localparam int LEN    = LINE_LENGTH_DEF;
   localparam int DEPTH  = HISTORY_DEPTH_DEF;
   localparam int CHUNKS = (LEN + 7) / 8;
   localparam int LAST   = LEN - 1;
   localparam int TEND   = LEN - 2;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic        done;
      logic        ins;
      logic [6:0]  cur;
      logic [3:0]  idx;
      logic [63:0] chunk;
   } chunk_type;

   typedef logic [7:0] line_type [LEN];

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_WIDTH-1:0] rsp_tdata;
   logic rsp_tlast;

   int errors = 0;
   int cycles = 0;
   bit hold_rsp = 0;
   bit no_idle = 0;

   line_editor_with_history_top uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   task automatic report(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   class line_scoreboard;
      line_type   line;
      line_type   hist [DEPTH];
      int         cur, browse_at, store_at;
      bit         ins;
      chunk_type  pending [$];

      function void clear_line();
         for (int i = 0; i < LAST; i++) line[i] = CHR_SPACE;
         line[LAST] = CHR_NUL;
         line[0] = CHR_PROMPT;
         cur = 1;
      endfunction

      function void start();
         for (int e = 0; e < DEPTH; e++)
            for (int i = 0; i < LEN; i++) hist[e][i] = CHR_NUL;
         for (int i = 0; i < LAST; i++) hist[0][i] = CHR_SPACE;
         clear_line();
         ins = 1;
         browse_at = 0;
         store_at = 0;
      endfunction

      function void to_end();
         cur = 0;
         for (int i = TEND; i >= 0; i--)
            if (line[i] != CHR_SPACE) begin
               cur = i + 1;
               break;
            end
      endfunction

      function void walk(bit fwd);
         int e;
         e = browse_at;
         for (int n = 0; n < DEPTH; n++) begin
            e = fwd ? (e == DEPTH - 1 ? 0 : e + 1) : (e == 0 ? DEPTH - 1 : e - 1);
            if (hist[e][0] != CHR_NUL) begin
               browse_at = e;
               line = hist[e];
               to_end();
               return;
            end
         end
      endfunction

      function void note_key(logic [REQ_WIDTH-1:0] d);
         logic [3:0] cmd;
         logic [7:0] ch;
         int fi, num, nlen, stop;
         bit done;
         logic [7:0] name [4];
         chunk_type r;
         cmd = d[3:0];
         ch = d[11:4];
         fi = d[16:12];
         done = 0;
         case (cmd)
            CMD_BEGIN: begin
               clear_line();
               browse_at = store_at;
            end
            CMD_CHAR: begin
               if (ins && cur < TEND)
                  for (int i = TEND; i > cur; i--) line[i] = line[i-1];
               if (cur < LAST) begin
                  line[cur] = ch;
                  cur++;
               end
            end
            CMD_CLEAR: clear_line();
            CMD_HOME: cur = 1;
            CMD_END: to_end();
            CMD_LEFT: if (cur > 1) cur--;
            CMD_RIGHT: if (cur < LAST) cur++;
            CMD_PREV: walk(0);
            CMD_NEXT: walk(1);
            CMD_INSTOG: ins = !ins;
            CMD_BKSP: if (cur > 1) begin
               for (int i = cur - 1; i < TEND; i++) line[i] = line[i+1];
               line[TEND] = CHR_SPACE;
               cur--;
            end
            CMD_DEL: if (cur < LAST) begin
               for (int i = cur; i < TEND; i++) line[i] = line[i+1];
               line[TEND] = CHR_SPACE;
            end
            CMD_ENTER: begin
               for (int e = 0; e < DEPTH; e++)
                  if (hist[e] == line) store_at = e;
               hist[store_at] = line;
               store_at = (store_at == DEPTH - 1) ? 0 : store_at + 1;
               to_end();
               line[cur] = CHR_NUL;
               done = 1;
            end
            CMD_FKEY: if (fi < FKEY_COUNT) begin
               nlen = 0;
               num = fi % FKEY_PER_BANK + 1;
               if (fi >= FKEY_PER_BANK) name[nlen++] = CHR_S;
               name[nlen++] = CHR_F;
               if (num >= 10) begin
                  name[nlen++] = CHR_ONE;
                  name[nlen++] = CHR_ZERO + 8'(num - 10);
               end else name[nlen++] = CHR_ZERO + 8'(num);
               for (int k = 0; k < nlen; k++)
                  if (cur + k < LAST) line[cur + k] = name[k];
               stop = cur + nlen;
               if (stop > LAST) stop = LAST;
               line[stop] = CHR_NUL;
               done = 1;
            end
            default: ;
         endcase
         for (int c = 0; c < CHUNKS; c++) begin
            r.chunk = '0;
            for (int b = 0; b < 8; b++)
               if (c * 8 + b < LEN) r.chunk[8*b +: 8] = line[c*8 + b];
            r.idx = 4'(c);
            r.cur = 7'(cur);
            r.ins = ins;
            r.done = done;
            pending.push_back(r);
         end
      endfunction

      task check_chunk(logic [RSP_WIDTH-1:0] d, logic tlast);
         chunk_type w;
         if (pending.size() == 0) begin
            report("chunk with nothing expected");
            return;
         end
         w = pending.pop_front();
         if (d[63:0] != w.chunk)
            report($sformatf("chunk %0d data %h want %h", w.idx, d[63:0], w.chunk));
         if (d[67:64] != w.idx) report($sformatf("index %0d want %0d", d[67:64], w.idx));
         if (tlast != (w.idx == CHUNKS - 1)) report($sformatf("tlast on chunk %0d", w.idx));
         if (d[74:68] != w.cur) report($sformatf("cursor %0d want %0d", d[74:68], w.cur));
         if (d[75] != w.ins) report($sformatf("insert mode %0b want %0b", d[75], w.ins));
         if (d[76] != w.done) report($sformatf("line done %0b want %0b", d[76], w.done));
      endtask
   endclass

   line_scoreboard board = new();

   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_key(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_chunk(rsp_tdata, rsp_tlast);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("line_editor_with_history_top_test failed");
         $finish;
      end
   end

   // receiver: random stall, or held off on request
   always @(negedge clock)
      rsp_tready <= !reset && !hold_rsp && (no_idle || $urandom_range(99) >= 21);

   task automatic send_key(input logic [3:0] cmd, input logic [7:0] ch, input logic [4:0] fi);
      if (!no_idle)
         while ($urandom_range(99) < 21) @(negedge clock);
      req_tvalid = 1;
      req_tdata = {7'b0, fi, ch, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic random_key();
      int p;
      logic [3:0] cmd;
      p = $urandom_range(99);
      if (p < 40) cmd = CMD_CHAR;
      else if (p < 46) cmd = CMD_ENTER;
      else if (p < 50) cmd = CMD_FKEY;
      else if (p < 53) cmd = CMD_BEGIN;
      else if (p < 55) cmd = 4'($urandom_range(15, 14));
      else cmd = 4'($urandom_range(13));
      send_key(cmd, 8'($urandom), (cmd == CMD_FKEY && $urandom_range(9) == 0)
               ? 5'($urandom_range(31, 24)) : 5'($urandom_range(23)));
   endtask

   initial begin
      board.start();
      repeat (7) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: every command, field extremes, edges of the line
      send_key(CMD_PREV, 0, 0);
      send_key(CMD_END, 0, 0);
      send_key(CMD_CHAR, 8'hFF, 0);
      send_key(CMD_CHAR, 8'h00, 0);
      send_key(CMD_LEFT, 0, 0);
      send_key(CMD_BKSP, 0, 0);
      send_key(CMD_DEL, 0, 0);
      send_key(CMD_HOME, 0, 0);
      send_key(CMD_LEFT, 0, 0);
      send_key(CMD_BKSP, 0, 0);
      send_key(CMD_FKEY, 0, 5'd11);
      send_key(CMD_FKEY, 0, 5'd23);
      send_key(CMD_FKEY, 0, 5'd31);
      send_key(CMD_ENTER, 0, 0);
      send_key(CMD_BEGIN, 0, 0);
      send_key(CMD_INSTOG, 0, 0);
      for (int i = 0; i < 82; i++) send_key(CMD_RIGHT, 0, 0);
      send_key(CMD_CHAR, 8'h55, 0);
      send_key(CMD_DEL, 0, 0);
      send_key(CMD_FKEY, 0, 5'd20);
      send_key(CMD_INSTOG, 0, 0);
      send_key(CMD_PREV, 0, 0);
      send_key(CMD_NEXT, 0, 0);
      send_key(4'd14, 0, 0);
      send_key(4'd15, 8'hAA, 5'h1F);
      send_key(CMD_CLEAR, 0, 0);
      drain();
      // long run of typing from the start of the line up to the right edge in insert mode
      for (int i = 0; i < 80; i++) send_key(CMD_CHAR, 8'($urandom), 0);
      send_key(CMD_ENTER, 0, 0);
      for (int i = 0; i < 10; i++) random_key();
      // receiver holds off while keys keep coming
      hold_rsp = 1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 6; i++) random_key();
      join
      drain();
      no_idle = 1;
      for (int i = 0; i < 25; i++) random_key();
      no_idle = 0;
      drain();
      for (int i = 0; i < 10; i++) random_key();
      drain();
      if (errors == 0) $display("line_editor_with_history_top_test passed");
      else $display("line_editor_with_history_top_test failed");
      $finish;
   end
endmodule
